// File: hw/rtl/ple_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine: request and
// result payloads, command and status codes, cell control and scan result.
// ----------------------------------------------------------------------------
package ple_pkg;

    // Default list capacity
    localparam int PLE_CAPACITY = 128;

    // Cells inspected by the search scanner in one cycle
    localparam int SCAN_GROUP   = 8;
    localparam int SCAN_GROUP_W = 3;

    // Fixed field widths
    localparam int CMD_W   = 3;
    localparam int POS_W   = 8;
    localparam int WORD_W  = 32;
    localparam int STAT_W  = 3;
    localparam int FOUND_W = 7;
    localparam int ECNT_W  = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 3'd0,
        CMD_READ   = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_SEARCH = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef struct packed {
        t_cmd                     cmd;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] word;
    } t_req;

    typedef struct packed {
        t_status                  status;
        logic [FOUND_W-1:0]       found_index;
        logic signed [WORD_W-1:0] read_word;
        logic [ECNT_W-1:0]        entry_count;
    } t_rsp;

    // What a cell loads this cycle
    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_LEFT  = 2'd2,
        OP_RIGHT = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     live;
        logic     cmp;
    } t_cell_ctl;

    typedef struct packed {
        logic               any;
        logic               last;
        logic [FOUND_W-1:0] index;
    } t_scan_res;

endpackage

// File: hw/rtl/ple_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds a word, takes its left or right neighbour's word on
// insert or delete, and latches a match flag on search.
// ----------------------------------------------------------------------------
module ple_cell (
    input  logic                              i_clk,
    input  ple_pkg::t_cell_ctl                i_ctl,
    input  logic signed [ple_pkg::WORD_W-1:0] i_word,
    input  logic signed [ple_pkg::WORD_W-1:0] i_left,
    input  logic signed [ple_pkg::WORD_W-1:0] i_right,
    output logic signed [ple_pkg::WORD_W-1:0] o_word,
    output logic                              o_hit
);

    logic signed [ple_pkg::WORD_W-1:0] r_word;
    logic                              r_hit;

    // Load, shift or hold the stored word
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            ple_pkg::OP_LOAD:  r_word <= i_word;
            ple_pkg::OP_LEFT:  r_word <= i_left;
            ple_pkg::OP_RIGHT: r_word <= i_right;
            default:           r_word <= r_word;
        endcase
    end

    // Latch the compare result for the scanner
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_hit <= i_ctl.live && (r_word == i_word);
        end
    end

    assign o_word = r_word;
    assign o_hit  = r_hit;

endmodule

// File: hw/rtl/ple_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_scan
// First-match finder: walks the latched match flags one group of cells per
// cycle while i_step is high and reports the lowest matching position.
// ----------------------------------------------------------------------------
module ple_scan #(
    parameter int CAPACITY = ple_pkg::PLE_CAPACITY
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_clear,
    input  logic                i_step,
    input  logic [CAPACITY-1:0] i_hits,
    output ple_pkg::t_scan_res  o_res
);

    localparam int NG   = (CAPACITY + ple_pkg::SCAN_GROUP - 1) / ple_pkg::SCAN_GROUP;
    localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
    localparam int PADW = NG * ple_pkg::SCAN_GROUP;

    logic [GW-1:0]                     r_grp;
    logic [GW-1:0]                     n_grp;
    logic [PADW-1:0]                   hits_pad;
    logic [ple_pkg::SCAN_GROUP-1:0]    grp_bits;
    logic [ple_pkg::SCAN_GROUP_W-1:0]  enc;

    assign hits_pad = PADW'(i_hits);
    assign grp_bits = hits_pad[r_grp * ple_pkg::SCAN_GROUP +: ple_pkg::SCAN_GROUP];

    // Pick the lowest set flag in the current group
    always_comb begin
        enc = '0;
        for (int k = ple_pkg::SCAN_GROUP - 1; k >= 0; k--) begin
            if (grp_bits[k]) begin
                enc = ple_pkg::SCAN_GROUP_W'(k);
            end
        end
    end

    // Restart on a new search, advance one group per scan cycle
    always_comb begin
        n_grp = r_grp;
        if (i_clear) begin
            n_grp = '0;
        end else if (i_step) begin
            n_grp = r_grp + GW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp <= '0;
        end else begin
            r_grp <= n_grp;
        end
    end

    assign o_res.any   = |grp_bits;
    assign o_res.last  = (r_grp == GW'(NG - 1));
    assign o_res.index = ple_pkg::FOUND_W'({r_grp, enc});

endmodule

// File: hw/rtl/positional_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine
// Dense ordered list of signed words held in a row of cells, with clear,
// read, insert, delete and first-match search commands.
// ----------------------------------------------------------------------------
// Clear, read, insert, delete and unused codes: result strobe in the cycle
// after the request, one request per cycle while busy is low.
// Search: cells compare in the request cycle, then the scanner checks eight
// cells a cycle; the result is strobed once a match is found or the last
// group is checked, busy held high meanwhile.
// Reset clears the count and the scanner; stored words are undefined until
// inserted. Results are strobed for one cycle and cannot be stalled.
module positional_list_engine #(
    parameter int CAPACITY = ple_pkg::PLE_CAPACITY
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  ple_pkg::t_req i_req,
    output logic          busy,
    output logic          o_done,
    output ple_pkg::t_rsp o_rsp
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state                              r_state;
    t_state                              n_state;
    logic [CW-1:0]                       r_count;
    logic [CW-1:0]                       n_count;
    logic                                n_done;
    ple_pkg::t_rsp                       n_rsp;

    logic                                accept;
    logic [PW-1:0]                       pos_ext;
    logic [PW-1:0]                       cnt_ext;
    logic [IW-1:0]                       pos_idx;
    logic                                ins_go;
    logic                                del_go;
    logic                                srch_go;

    logic signed [ple_pkg::WORD_W-1:0]   w_word [CAPACITY];
    logic [CAPACITY-1:0]                 w_hit;
    ple_pkg::t_cell_ctl                  w_ctl  [CAPACITY];
    ple_pkg::t_scan_res                  scan;

    assign busy    = (r_state == S_SCAN);
    assign accept  = start && !busy;
    assign pos_ext = PW'(i_req.position);
    assign cnt_ext = PW'(r_count);
    assign pos_idx = IW'(i_req.position);

    // Decode the request into status, new count and cell commands
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_done  = 1'b0;
        n_rsp   = o_rsp;
        ins_go  = 1'b0;
        del_go  = 1'b0;
        srch_go = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_done            = 1'b1;
                    n_rsp.status      = ple_pkg::ST_OK;
                    n_rsp.found_index = '0;
                    n_rsp.read_word   = '0;
                    case (i_req.cmd)
                        ple_pkg::CMD_CLEAR: begin
                            n_count = '0;
                        end
                        ple_pkg::CMD_READ: begin
                            if (r_count == '0) begin
                                n_rsp.status = ple_pkg::ST_EMPTY;
                            end else if (pos_ext >= cnt_ext) begin
                                n_rsp.status = ple_pkg::ST_BADPOS;
                            end else begin
                                n_rsp.read_word = w_word[pos_idx];
                            end
                        end
                        ple_pkg::CMD_INSERT: begin
                            if (r_count >= CW'(CAPACITY)) begin
                                n_rsp.status = ple_pkg::ST_FULL;
                            end else if (pos_ext > cnt_ext) begin
                                n_rsp.status = ple_pkg::ST_BADPOS;
                            end else begin
                                ins_go  = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        ple_pkg::CMD_DELETE: begin
                            if (r_count == '0) begin
                                n_rsp.status = ple_pkg::ST_EMPTY;
                            end else if (pos_ext >= cnt_ext) begin
                                n_rsp.status = ple_pkg::ST_BADPOS;
                            end else begin
                                del_go  = 1'b1;
                                n_count = r_count - CW'(1);
                            end
                        end
                        ple_pkg::CMD_SEARCH: begin
                            srch_go = 1'b1;
                            n_done  = 1'b0;
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_count = r_count;
                        end
                    endcase
                    n_rsp.entry_count = ple_pkg::ECNT_W'(n_count);
                end
            end
            S_SCAN: begin
                if (scan.any) begin
                    n_done            = 1'b1;
                    n_rsp.status      = ple_pkg::ST_OK;
                    n_rsp.found_index = scan.index;
                    n_state           = S_IDLE;
                end else if (scan.last) begin
                    n_done            = 1'b1;
                    n_rsp.status      = ple_pkg::ST_NOTFOUND;
                    n_rsp.found_index = '0;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, count and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            o_done  <= n_done;
        end
        o_rsp <= n_rsp;
    end

    // Row of cells: each works out its own move from its position
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        localparam logic [PW-1:0] IDX = PW'(i);

        logic signed [ple_pkg::WORD_W-1:0] left_w;
        logic signed [ple_pkg::WORD_W-1:0] right_w;

        always_comb begin
            w_ctl[i].op   = ple_pkg::OP_HOLD;
            w_ctl[i].live = (IDX < cnt_ext);
            w_ctl[i].cmp  = srch_go;
            if (ins_go) begin
                if (IDX > pos_ext) begin
                    w_ctl[i].op = ple_pkg::OP_LEFT;
                end else if (IDX == pos_ext) begin
                    w_ctl[i].op = ple_pkg::OP_LOAD;
                end
            end else if (del_go && (IDX >= pos_ext)) begin
                w_ctl[i].op = ple_pkg::OP_RIGHT;
            end
        end

        if (i == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = w_word[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_w = w_word[i];
        end else begin : g_mid_r
            assign right_w = w_word[i+1];
        end

        ple_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[i]),
            .i_word  (i_req.word),
            .i_left  (left_w),
            .i_right (right_w),
            .o_word  (w_word[i]),
            .o_hit   (w_hit[i])
        );
    end

    // First-match scanner over the latched flags
    ple_scan #(
        .CAPACITY (CAPACITY)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (srch_go),
        .i_step  (busy),
        .i_hits  (w_hit),
        .o_res   (scan)
    );

    // Count never exceeds the capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("list count beyond capacity");

    // Non-search requests answer in the next cycle
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.cmd != ple_pkg::CMD_SEARCH)) |=> (o_done && !busy))
        else $error("missing single-cycle result");

    // Search holds busy and gives no strobe on the next cycle
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.cmd == ple_pkg::CMD_SEARCH)) |=> (busy && !o_done))
        else $error("search did not enter scan");

    // A scan hit or the last group ends the search with a strobe
    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && (scan.any || scan.last)) |=> (o_done && !busy))
        else $error("scan end without result");

    // Full is only reported on a full list
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status == ple_pkg::ST_FULL)) |->
            (o_rsp.entry_count == ple_pkg::ECNT_W'(CAPACITY)))
        else $error("full status with spare room");

endmodule
